[rtl/nte_pkg.sv]
// Package for the neighbour table engine: field widths, request and status codes,
// request, result and table entry types. It depends on nothing else.
`default_nettype none
package nte_pkg;

  localparam int unsigned ENTRIES_DEF = 1024;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned PORT_W      = 8;
  localparam int unsigned STATE_W     = 8;
  localparam int unsigned TOTAL_W     = 10;
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned STATUS_W    = 3;

  typedef enum logic [REQ_W-1:0] {
    RQ_LOOKUP  = 3'd0,
    RQ_ADD     = 3'd1,
    RQ_REPLACE = 3'd2,
    RQ_REMOVE  = 3'd3,
    RQ_UPDATE  = 3'd4
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_PRESENT     = 3'd2,
    ST_FULL        = 3'd3,
    ST_NOT_UNKNOWN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ES_CLEAR,
    ES_IDLE,
    ES_SCAN,
    ES_APPLY
  } eng_state_e;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [KEY_W-1:0]   ip_key;
    logic [PORT_W-1:0]  port_id;
    logic [MAC_W-1:0]   mac_addr;
    logic [STATE_W-1:0] new_state;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [MAC_W-1:0]    found_mac;
    logic [PORT_W-1:0]   found_port;
    logic [STATE_W-1:0]  found_state;
    logic [TOTAL_W-1:0]  entry_total;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [MAC_W-1:0]   mac;
    logic [PORT_W-1:0]  port;
    logic [STATE_W-1:0] state;
  } slot_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } eng_stat_t;

endpackage
`default_nettype wire

[rtl/nte_if.sv]
// Request and result channel interfaces of the neighbour table engine.
// They depend on nte_pkg for the field widths.
`default_nettype none
interface nte_req_if import nte_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [KEY_W-1:0]   ip_key;
  logic [PORT_W-1:0]  port_id;
  logic [MAC_W-1:0]   mac_addr;
  logic [STATE_W-1:0] new_state;
  modport source (output valid, req_type, ip_key, port_id, mac_addr, new_state, input ready);
  modport sink   (input valid, req_type, ip_key, port_id, mac_addr, new_state, output ready);
endinterface

interface nte_rsp_if import nte_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                hit;
  logic [MAC_W-1:0]    found_mac;
  logic [PORT_W-1:0]   found_port;
  logic [STATE_W-1:0]  found_state;
  logic [TOTAL_W-1:0]  entry_total;
  modport source (output valid, status, hit, found_mac, found_port, found_state, entry_total,
                  input ready);
  modport sink   (input valid, status, hit, found_mac, found_port, found_state, entry_total,
                  output ready);
endinterface
`default_nettype wire

[rtl/nte_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing else.
`default_nettype none
module nte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/nte_engine.sv]
// Sequencer of the neighbour table: clearing pass, table scan, read-modify-write
// and result register. It depends on nte_pkg and nte_ram.
`default_nettype none
module nte_engine import nte_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [STATE_W-1:0] unknown_code_i,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire req_t               req_i,
  output logic                    rsp_valid_o,
  input  wire logic               rsp_ready_i,
  output rsp_t                    rsp_o,
  output eng_stat_t               stat_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = (AW > TOTAL_W) ? AW : TOTAL_W;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  eng_state_e state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] count_q, count_d;
  logic [AW-1:0] match_idx_q, match_idx_d, free_idx_q, free_idx_d;
  logic          match_q, match_d, free_q, free_d;
  slot_t         match_slot_q, match_slot_d;
  req_t          req_q, req_d;
  rsp_t          rsp_q, rsp_d;
  logic          rsp_valid_q, rsp_valid_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  slot_t         wdata, rdata;
  logic          go, full, hit_now, free_now;
  logic [CW-1:0] total_ext;

  nte_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign go       = !rsp_valid_q || rsp_ready_i;
  assign full     = (count_q == LAST);
  assign hit_now  = rdata.valid && (rdata.key == req_q.ip_key);
  assign free_now = !rdata.valid;
  assign raddr    = (state_q == ES_SCAN) ? addr_q + AW'(1) : '0;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ES_CLEAR: if (addr_q == LAST) state_d = ES_IDLE;
      ES_IDLE:  if (req_valid_i) state_d = ES_SCAN;
      ES_SCAN:  if (addr_q == LAST) state_d = ES_APPLY;
      ES_APPLY: if (go) state_d = ES_IDLE;
      default:  state_d = ES_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    addr_d       = addr_q;
    count_d      = count_q;
    match_d      = match_q;
    match_idx_d  = match_idx_q;
    match_slot_d = match_slot_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    req_d        = req_q;
    rsp_d        = rsp_q;
    rsp_valid_d  = rsp_valid_q && !rsp_ready_i;
    we           = 1'b0;
    waddr        = addr_q;
    wdata        = '0;
    total_ext    = '0;

    case (state_q)
      ES_CLEAR: begin
        we     = 1'b1;
        addr_d = addr_q + AW'(1);
      end
      ES_IDLE: begin
        addr_d  = '0;
        match_d = 1'b0;
        free_d  = 1'b0;
        if (req_valid_i) begin
          req_d = req_i;
        end
      end
      ES_SCAN: begin
        if (hit_now && !match_q) begin
          match_d      = 1'b1;
          match_idx_d  = addr_q;
          match_slot_d = rdata;
        end
        if (free_now && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = addr_q;
        end
        addr_d = addr_q + AW'(1);
      end
      ES_APPLY: begin
        rsp_d        = '0;
        rsp_d.hit    = match_q;
        rsp_d.status = ST_OK;
        wdata.valid  = 1'b1;
        wdata.key    = req_q.ip_key;
        wdata.port   = req_q.port_id;
        wdata.state  = unknown_code_i;
        case (req_q.req_type)
          RQ_LOOKUP: begin
            if (match_q) begin
              rsp_d.found_mac   = match_slot_q.mac;
              rsp_d.found_port  = match_slot_q.port;
              rsp_d.found_state = match_slot_q.state;
            end else begin
              rsp_d.status = ST_NOT_FOUND;
            end
          end
          RQ_ADD, RQ_REPLACE: begin
            if (match_q && req_q.req_type == RQ_REPLACE) begin
              we    = go;
              waddr = match_idx_q;
            end else if (match_q) begin
              rsp_d.status = ST_PRESENT;
            end else if (full || !free_q) begin
              rsp_d.status = ST_FULL;
            end else begin
              we    = go;
              waddr = free_idx_q;
              if (go) count_d = count_q + AW'(1);
            end
          end
          RQ_REMOVE: begin
            if (match_q) begin
              we          = go;
              waddr       = match_idx_q;
              wdata.valid = 1'b0;
              if (go) count_d = count_q - AW'(1);
            end else begin
              rsp_d.status = ST_NOT_FOUND;
            end
          end
          RQ_UPDATE: begin
            if (!match_q) begin
              rsp_d.status = ST_NOT_FOUND;
            end else if (match_slot_q.state != unknown_code_i) begin
              rsp_d.status = ST_NOT_UNKNOWN;
            end else begin
              we          = go;
              waddr       = match_idx_q;
              wdata.mac   = req_q.mac_addr;
              wdata.port  = match_slot_q.port;
              wdata.state = req_q.new_state;
            end
          end
          default: ;
        endcase
        total_ext         = CW'(count_d);
        rsp_d.entry_total = total_ext[TOTAL_W-1:0];
        if (!go) begin
          rsp_d = rsp_q;
        end else begin
          rsp_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ES_CLEAR;
      addr_q      <= '0;
      count_q     <= '0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      count_q     <= count_d;
      match_q     <= match_d;
      free_q      <= free_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q  <= match_idx_d;
    match_slot_q <= match_slot_d;
    free_idx_q   <= free_idx_d;
    req_q        <= req_d;
    rsp_q        <= rsp_d;
  end

  assign req_ready_o    = (state_q == ES_IDLE);
  assign rsp_valid_o    = rsp_valid_q;
  assign rsp_o          = rsp_q;
  assign stat_o.clearing = (state_q == ES_CLEAR);
  assign stat_o.busy     = (state_q == ES_SCAN) || (state_q == ES_APPLY);

endmodule
`default_nettype wire

[rtl/neighbour_table_engine.sv]
// Top level of the neighbour table engine: configuration register, channel wiring
// and checks. It depends on nte_pkg, nte_if and nte_engine.
//
// Usage. Requests arrive on req_i (lookup, add, replace, remove, update) and each
// gives exactly one result on rsp_o, in order. A request is taken when valid and
// ready are both high at a rising edge of clk_i. The table lives in one memory of
// ENTRIES words; every request scans all of it, one word a cycle, to find the key
// and the lowest free slot, and then does the write-back. No new request is taken
// until that write-back is done, as the memory read port is walked once per request.
// The result sits in an output register. A new request is accepted while an
// earlier result waits; if the receiver stalls, the write-back of the next request
// waits until that result has been taken, so nothing is lost.
// After reset the block runs a clearing pass over the memory, during which no
// request is accepted; the configuration port works throughout.
// The register unknown_state_code lies at byte address 0 of the APB-style port;
// the user writes it only while the block is idle; the block does not enforce this.
`default_nettype none
module neighbour_table_engine import nte_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  nte_req_if.sink          req_i,
  nte_rsp_if.source        rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [STATE_W-1:0] unknown_code_q, unknown_code_d;
  req_t      req;
  rsp_t      rsp;
  eng_stat_t stat;
  logic      cfg_wr;

  // Only index 0 exists; a write to any other word is dropped.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_comb begin
    unknown_code_d = unknown_code_q;
    if (cfg_wr) unknown_code_d = pwdata[STATE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unknown_code_q <= '0;
    end else begin
      unknown_code_q <= unknown_code_d;
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {{(32-STATE_W){1'b0}}, unknown_code_q} : 32'd0;

  assign req.req_type  = req_i.req_type;
  assign req.ip_key    = req_i.ip_key;
  assign req.port_id   = req_i.port_id;
  assign req.mac_addr  = req_i.mac_addr;
  assign req.new_state = req_i.new_state;

  nte_engine #(
    .ENTRIES(ENTRIES)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .unknown_code_i(unknown_code_q),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_i         (req),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_o         (rsp),
    .stat_o        (stat)
  );

  assign rsp_o.status      = rsp.status;
  assign rsp_o.hit         = rsp.hit;
  assign rsp_o.found_mac   = rsp.found_mac;
  assign rsp_o.found_port  = rsp.found_port;
  assign rsp_o.found_state = rsp.found_state;
  assign rsp_o.entry_total = rsp.entry_total;

  // The block serves one request at a time: straight after acceptance it is busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready && stat.busy)
    else $error("request accepted while another is in flight");

  // No request is taken while the memory is being cleared.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !req_i.ready)
    else $error("request accepted during the clearing pass");

  // A hit can never report a missing key, and a miss can never report a present one.
  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.status == ST_NOT_FOUND)
                 && !(!rsp_o.hit && rsp_o.status == ST_PRESENT))
    else $error("hit flag disagrees with status");

  // Found fields are only non-zero on a successful lookup.
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.hit |-> rsp_o.found_mac == '0 && rsp_o.found_port == '0
                                 && rsp_o.found_state == '0)
    else $error("found fields set on a miss");

endmodule
`default_nettype wire
